### design/efc_pkg.sv
// shared types and constants for the ethernet frame classifier
`default_nettype none

package efc_pkg;

    localparam int COUNT_WIDTH_DEF     = 32;
    localparam int MAX_FRAME_BYTES_DEF = 2048;

    localparam int ETH_HDR = 14;
    localparam int V6_HDR  = 40;
    localparam int IP4_NEED = ETH_HDR + 10;
    localparam int IP6_NEED = ETH_HDR + 7;

    localparam logic [15:0] ET_ARP = 16'h0806;
    localparam logic [15:0] ET_IP4 = 16'h0800;
    localparam logic [15:0] ET_IP6 = 16'h86DD;

    localparam logic [7:0] PR_TCP   = 8'd6;
    localparam logic [7:0] PR_UDP   = 8'd17;
    localparam logic [7:0] PR_ICMP4 = 8'd1;
    localparam logic [7:0] PR_ICMP6 = 8'd58;

    localparam logic [15:0] WEB_PORT_RESET = 16'd80;
    localparam logic [2:0]  ADDR_WEB_PORT  = 3'd0;

    localparam int NUM_COUNTERS = 10;
    localparam int CNT_TOTAL = 0;
    localparam int CNT_OTHER = 1;
    localparam int CNT_ARP   = 2;
    localparam int CNT_IP4   = 3;
    localparam int CNT_IP6   = 4;
    localparam int CNT_TCP   = 5;
    localparam int CNT_HTTP  = 6;
    localparam int CNT_UDP   = 7;
    localparam int CNT_ICMP4 = 8;
    localparam int CNT_ICMP6 = 9;

    typedef enum logic [3:0] {
        CLS_OTHER = 4'd0,
        CLS_ARP   = 4'd1,
        CLS_IP4   = 4'd2,
        CLS_IP6   = 4'd3,
        CLS_TCP   = 4'd4,
        CLS_HTTP  = 4'd5,
        CLS_UDP   = 4'd6,
        CLS_ICMP4 = 4'd7,
        CLS_ICMP6 = 4'd8
    } frame_class_t;

    // header fields of the frame as they stand after the current item
    typedef struct packed {
        logic [15:0] ether_kind;
        logic [7:0]  next_protocol;
        logic [15:0] source_port;
        logic [15:0] dst_port;
        logic        short_eth;
        logic        short_ip4;
        logic        short_ip6;
        logic        short_l4;
    } frame_info_t;

endpackage

`default_nettype wire

### design/efc_parse.sv
// per-frame byte position tracking and header field capture
`default_nettype none

module efc_parse
    import efc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        end_of_frame,
    output frame_info_t      info
);

    localparam int PW = ($clog2(MAX_FRAME_BYTES + 1) > 8) ? $clog2(MAX_FRAME_BYTES + 1) : 8;

    logic [PW-1:0] pos_reg,   pos_next;
    logic [15:0]   kind_reg,  kind_next;
    logic [3:0]    hw_reg,    hw_next;
    logic [7:0]    proto_reg, proto_next;
    logic [15:0]   sport_reg, sport_next;
    logic [15:0]   dport_reg, dport_next;

    logic          take;
    logic [7:0]    l4_start;
    logic [PW-1:0] l4_off;
    logic          is_ip;

    always_comb
    begin
        take       = pos_reg < PW'(MAX_FRAME_BYTES);
        pos_next   = take ? pos_reg + PW'(1) : pos_reg;
        kind_next  = kind_reg;
        hw_next    = hw_reg;
        proto_next = proto_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;

        if (take && pos_reg == PW'(12))
        begin
            kind_next = {frame_byte, kind_reg[7:0]};
        end
        if (take && pos_reg == PW'(13))
        begin
            kind_next = {kind_reg[15:8], frame_byte};
        end

        is_ip = 1'b0;
        if (take && pos_reg >= PW'(ETH_HDR))
        begin
            if (kind_next == ET_IP4)
            begin
                is_ip = 1'b1;
                if (pos_reg == PW'(ETH_HDR))
                begin
                    hw_next = frame_byte[3:0];
                end
                if (pos_reg == PW'(ETH_HDR + 9))
                begin
                    proto_next = frame_byte;
                end
            end
            else if (kind_next == ET_IP6)
            begin
                is_ip = 1'b1;
                if (pos_reg == PW'(ETH_HDR + 6))
                begin
                    proto_next = frame_byte;
                end
            end
        end

        // the ihl nibble may land in this very item, so use its new value
        if (kind_next == ET_IP6)
        begin
            l4_start = 8'(ETH_HDR + V6_HDR);
        end
        else
        begin
            l4_start = 8'(ETH_HDR) + {2'b00, hw_next, 2'b00};
        end
        l4_off = pos_reg - PW'(l4_start);

        if (is_ip && pos_reg >= PW'(l4_start) && l4_off < PW'(4))
        begin
            case (l4_off[1:0])
                2'd0:    sport_next = {frame_byte, sport_reg[7:0]};
                2'd1:    sport_next = {sport_reg[15:8], frame_byte};
                2'd2:    dport_next = {frame_byte, dport_reg[7:0]};
                default: dport_next = {dport_reg[15:8], frame_byte};
            endcase
        end

        info.ether_kind    = kind_next;
        info.next_protocol = proto_next;
        info.source_port   = sport_next;
        info.dst_port      = dport_next;
        info.short_eth     = pos_next < PW'(ETH_HDR);
        info.short_ip4     = pos_next < PW'(IP4_NEED);
        info.short_ip6     = pos_next < PW'(IP6_NEED);
        info.short_l4      = pos_next < PW'(l4_start) + PW'(4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            kind_reg  <= '0;
            hw_reg    <= '0;
            proto_reg <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
        end
        else if (go)
        begin
            if (end_of_frame)
            begin
                pos_reg   <= '0;
                kind_reg  <= '0;
                hw_reg    <= '0;
                proto_reg <= '0;
                sport_reg <= '0;
                dport_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                kind_reg  <= kind_next;
                hw_reg    <= hw_next;
                proto_reg <= proto_next;
                sport_reg <= sport_next;
                dport_reg <= dport_next;
            end
        end
    end

endmodule

`default_nettype wire

### design/ethernet_frame_classifier.sv
// top level of the ethernet frame classifier
//
// Frame bytes enter on the s_axis side, one item per byte with tlast on the last byte of a
// frame. The block takes one item every cycle: each byte is registered, then parsed
// against the frame's captured header fields, and on the last byte the class, ports,
// protocol and updated saturating counters are loaded into the result register. The
// input side stalls only when a last byte finds the result register still full and not
// being taken downstream. web_port is written through the apb port; the user must write it
// only while no frame is in flight, as the block itself does not enforce this.
`default_nettype none

module ethernet_frame_classifier
    import efc_pkg::*;
#(
    parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF,
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // frame_byte
    input  wire logic         s_axis_tlast,   // end_of_frame
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // source_port, dst_port, ip_protocol, total_frames, class_frames, ip_frames
    output logic [135:0]      m_axis_tdata,
    output logic [4:0]        m_axis_tuser,   // frame_class, truncated
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef logic [COUNT_WIDTH-1:0] count_t;

    function automatic logic [31:0] low32(input count_t v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    // configuration
    logic [15:0] web_port_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WEB_PORT) ? {16'd0, web_port_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            web_port_reg <= WEB_PORT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_WEB_PORT)
        begin
            web_port_reg <= pwdata[15:0];
        end
    end

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       go;
    logic       finish;

    assign go     = in_valid_reg && (!in_last_reg || !m_axis_tvalid || m_axis_tready);
    assign finish = go && in_last_reg;
    assign s_axis_tready = !in_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    frame_info_t info;

    efc_parse #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (go),
        .frame_byte   (in_byte_reg),
        .end_of_frame (in_last_reg),
        .info         (info)
    );

    // classification
    frame_class_t            cls;
    logic                    trunc;
    logic                    use_ports;
    logic [7:0]              proto;
    logic [NUM_COUNTERS-1:0] bump_en;
    logic                    hit_ip4;
    logic                    hit_ip6;
    logic                    v6;
    logic                    is_tcp;
    logic                    is_udp;

    always_comb
    begin
        cls       = CLS_OTHER;
        trunc     = 1'b0;
        use_ports = 1'b0;
        proto     = 8'd0;
        bump_en   = '0;
        hit_ip4   = 1'b0;
        hit_ip6   = 1'b0;
        v6        = info.ether_kind == ET_IP6;
        is_tcp    = info.next_protocol == PR_TCP;
        is_udp    = info.next_protocol == PR_UDP;
        bump_en[CNT_TOTAL] = 1'b1;

        if (info.short_eth)
        begin
            trunc = 1'b1;
        end
        else if (info.ether_kind == ET_ARP)
        begin
            cls = CLS_ARP;
            bump_en[CNT_ARP] = 1'b1;
        end
        else if (info.ether_kind == ET_IP4 || v6)
        begin
            if (v6 ? info.short_ip6 : info.short_ip4)
            begin
                trunc = 1'b1;
            end
            else if ((is_tcp || is_udp) && info.short_l4)
            begin
                trunc = 1'b1;
            end
            else
            begin
                hit_ip4 = !v6;
                hit_ip6 = v6;
                bump_en[CNT_IP4] = !v6;
                bump_en[CNT_IP6] = v6;
                proto     = info.next_protocol;
                use_ports = is_tcp || is_udp;
                if (is_tcp)
                begin
                    if (info.source_port == web_port_reg || info.dst_port == web_port_reg)
                    begin
                        cls = CLS_HTTP;
                        bump_en[CNT_HTTP] = 1'b1;
                    end
                    else
                    begin
                        cls = CLS_TCP;
                        bump_en[CNT_TCP] = 1'b1;
                    end
                end
                else if (is_udp)
                begin
                    cls = CLS_UDP;
                    bump_en[CNT_UDP] = 1'b1;
                end
                else if (!v6 && info.next_protocol == PR_ICMP4)
                begin
                    cls = CLS_ICMP4;
                    bump_en[CNT_ICMP4] = 1'b1;
                end
                else if (v6 && info.next_protocol == PR_ICMP6)
                begin
                    cls = CLS_ICMP6;
                    bump_en[CNT_ICMP6] = 1'b1;
                end
                else
                begin
                    cls = v6 ? CLS_IP6 : CLS_IP4;
                end
            end
        end
        else
        begin
            bump_en[CNT_OTHER] = 1'b1;
        end
    end

    // saturating counters
    count_t cnt_reg [NUM_COUNTERS];
    count_t bumped  [NUM_COUNTERS];

    for (genvar i = 0; i < NUM_COUNTERS; i++)
    begin : g_cnt
        assign bumped[i] = (cnt_reg[i] == {COUNT_WIDTH{1'b1}}) ? cnt_reg[i]
                                                               : cnt_reg[i] + count_t'(1);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[i] <= '0;
            end
            else if (finish && bump_en[i])
            begin
                cnt_reg[i] <= bumped[i];
            end
        end
    end

    logic [31:0] class_cnt;
    logic [31:0] ip_cnt;

    always_comb
    begin
        case (cls)
            CLS_OTHER: class_cnt = low32(bumped[CNT_OTHER]);
            CLS_ARP:   class_cnt = low32(bumped[CNT_ARP]);
            CLS_IP4:   class_cnt = low32(bumped[CNT_IP4]);
            CLS_IP6:   class_cnt = low32(bumped[CNT_IP6]);
            CLS_TCP:   class_cnt = low32(bumped[CNT_TCP]);
            CLS_HTTP:  class_cnt = low32(bumped[CNT_HTTP]);
            CLS_UDP:   class_cnt = low32(bumped[CNT_UDP]);
            CLS_ICMP4: class_cnt = low32(bumped[CNT_ICMP4]);
            CLS_ICMP6: class_cnt = low32(bumped[CNT_ICMP6]);
            default:   class_cnt = 32'd0;
        endcase
        if (trunc)
        begin
            class_cnt = 32'd0;
        end

        if (hit_ip4)
        begin
            ip_cnt = low32(bumped[CNT_IP4]);
        end
        else if (hit_ip6)
        begin
            ip_cnt = low32(bumped[CNT_IP6]);
        end
        else
        begin
            ip_cnt = 32'd0;
        end
    end

    // result register
    logic         out_valid_reg;
    logic [135:0] out_data_reg;
    logic [4:0]   out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_user_reg <= {trunc, cls};
            out_data_reg <= {ip_cnt,
                             class_cnt,
                             low32(bumped[CNT_TOTAL]),
                             proto,
                             use_ports ? info.dst_port : 16'd0,
                             use_ports ? info.source_port : 16'd0};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

`default_nettype wire

### design/efc_checker.sv
// port-level checks for the ethernet frame classifier, bound to the top level
`default_nettype none

module efc_checker
    import efc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tready,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [135:0] m_axis_tdata,
    input  wire logic [4:0]   m_axis_tuser
);

    // a pending result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // input only backs up behind a full result register
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with result register empty");

    // a cut-short frame carries no class, ports or class counts
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[4] |->
            m_axis_tuser[3:0] == CLS_OTHER && m_axis_tdata[39:0] == 40'd0 &&
            m_axis_tdata[135:72] == 64'd0)
        else $error("truncated frame carries classification fields");

    // a classified frame always shows its bumped class counter
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[4] |->
            m_axis_tdata[103:72] != 32'd0 && m_axis_tdata[71:40] != 32'd0)
        else $error("class or total counter missing on classified frame");

    // ports only appear for tcp, http and udp
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3:0] != CLS_TCP && m_axis_tuser[3:0] != CLS_HTTP &&
            m_axis_tuser[3:0] != CLS_UDP |-> m_axis_tdata[31:0] == 32'd0)
        else $error("ports reported for a non-transport class");

endmodule

bind ethernet_frame_classifier efc_checker u_efc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
